FILE: src/fwm_pkg.sv
// Shared types and constants of the frame rate window meter.
// No dependencies; imported by every module of the block.
package fwm_pkg;

  localparam int BUCKETS   = 9;
  localparam int STAMP_W   = 32;
  localparam int CNT_W     = 16;
  localparam int RATE_W    = 16;
  localparam int IDX_W     = $clog2(BUCKETS);
  localparam int SUM_W     = CNT_W + $clog2(BUCKETS);
  localparam int RATE_DIV  = BUCKETS - 1;
  localparam int RATE_HALF = (BUCKETS - 1) / 2;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC_SCAN,
    ST_REC_COMMIT,
    ST_MAX_SCAN,
    ST_SUM_SCAN,
    ST_RESP
  } fwm_state_e;

  typedef struct packed {
    logic start;
    logic step;
    logic rec_scan;
    logic max_scan;
    logic sum_scan;
    logic commit;
    logic load_out;
  } fwm_cmd_t;

  typedef struct packed {
    logic is_query;
    logic last;
  } fwm_sts_t;

endpackage

FILE: src/fwm_ctrl.sv
// Controller state machine of the frame rate window meter.
// Depends on fwm_pkg; drives fwm_dp through command and status structs.
module fwm_ctrl import fwm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  fwm_sts_t sts_i,
  output fwm_cmd_t cmd_o
);

  fwm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_REC_SCAN;
        end
      end
      ST_REC_SCAN: begin
        if (sts_i.is_query) begin
          state_d = ST_MAX_SCAN;
        end else begin
          cmd_o.rec_scan = 1'b1;
          cmd_o.step     = 1'b1;
          if (sts_i.last) begin
            state_d = ST_REC_COMMIT;
          end
        end
      end
      ST_REC_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_RESP;
      end
      ST_MAX_SCAN: begin
        cmd_o.max_scan = 1'b1;
        cmd_o.step     = 1'b1;
        if (sts_i.last) begin
          state_d = ST_SUM_SCAN;
        end
      end
      ST_SUM_SCAN: begin
        cmd_o.sum_scan = 1'b1;
        cmd_o.step     = 1'b1;
        if (sts_i.last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/fwm_dp.sv
// Datapath of the frame rate window meter: bucket table, scan index,
// hit/victim tracking, max and sum accumulators, result register. Uses fwm_pkg.
module fwm_dp import fwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fwm_cmd_t           cmd_i,
  output fwm_sts_t           sts_o,
  input  logic               op_i,
  input  logic [STAMP_W-1:0] second_i,
  output logic [RATE_W-1:0]  rate_o,
  output logic               recorded_o
);

  logic [STAMP_W-1:0] stamp_q [BUCKETS];
  logic [CNT_W-1:0]   count_q [BUCKETS];
  logic [STAMP_W-1:0] sec_q;
  logic               op_q;
  logic [IDX_W-1:0]   idx_q;
  logic               hit_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic [IDX_W-1:0]   victim_q;
  logic [STAMP_W-1:0] max_q;
  logic [SUM_W-1:0]   sum_q;
  logic [RATE_W-1:0]  rate_q;
  logic               recorded_q;

  logic [STAMP_W-1:0] cur_stamp;
  logic [CNT_W-1:0]   cur_count;
  logic [STAMP_W-1:0] rec_limit;
  logic [STAMP_W-1:0] sum_floor;
  logic               last;
  logic [SUM_W:0]     sum_rnd;
  logic [SUM_W:0]     quot;
  logic [RATE_W-1:0]  rate_sat;
  logic [IDX_W-1:0]   wr_idx;

  assign cur_stamp = stamp_q[idx_q];
  assign cur_count = count_q[idx_q];
  assign rec_limit = sec_q - STAMP_W'(BUCKETS);
  assign sum_floor = max_q - STAMP_W'(BUCKETS);
  assign last      = (idx_q == IDX_W'(BUCKETS - 1));
  assign sum_rnd   = {1'b0, sum_q} + (SUM_W + 1)'(RATE_HALF);
  assign quot      = sum_rnd / (SUM_W + 1)'(RATE_DIV);
  assign rate_sat  = (quot > (SUM_W + 1)'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
  assign wr_idx    = hit_q ? hit_idx_q : victim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUCKETS; i++) begin
        stamp_q[i] <= '0;
        count_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      if (hit_q) begin
        if (count_q[wr_idx] != CNT_MAX) begin
          count_q[wr_idx] <= count_q[wr_idx] + CNT_W'(1);
        end
      end else begin
        stamp_q[wr_idx] <= sec_q;
        count_q[wr_idx] <= CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sec_q    <= second_i;
      op_q     <= op_i;
      idx_q    <= '0;
      hit_q    <= 1'b0;
      hit_idx_q <= '0;
      victim_q <= '0;
      max_q    <= '0;
      sum_q    <= '0;
    end else begin
      if (cmd_i.step) begin
        idx_q <= last ? '0 : idx_q + IDX_W'(1);
      end
      if (cmd_i.rec_scan) begin
        if (!hit_q && cur_stamp == sec_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= idx_q;
        end
        if (cur_stamp <= rec_limit) begin
          victim_q <= idx_q;
        end
      end
      if (cmd_i.max_scan && cur_stamp > max_q) begin
        max_q <= cur_stamp;
      end
      if (cmd_i.sum_scan && cur_stamp > sum_floor && cur_stamp != max_q) begin
        sum_q <= sum_q + SUM_W'(cur_count);
      end
    end
    if (cmd_i.load_out) begin
      rate_q     <= op_q ? rate_sat : '0;
      recorded_q <= !op_q;
    end
  end

  assign sts_o.is_query = op_q;
  assign sts_o.last     = last;
  assign rate_o         = rate_q;
  assign recorded_o     = recorded_q;

endmodule

FILE: src/frame_rate_window_meter_top.sv
// Top level of the frame rate window meter.
// Instantiates fwm_ctrl and fwm_dp; uses fwm_pkg.
//
// Usage:
//   Input stream: s_axis_tuser is the op (0 records one event at the second
//   in s_axis_tdata, 1 queries the rate; tdata is ignored for queries).
//   Output stream: one word per input word. m_axis_tdata is the rate
//   (zero for records), m_axis_tuser is set for a record.
//   A record walks the nine buckets one per cycle, then updates one bucket.
//   A query walks the buckets twice (newest stamp, then windowed sum) and
//   rounds the sum. One word is in work at a time; s_axis_tready is high
//   only while idle, so a new word is taken only once the last one has been
//   loaded into the output register.
//   The result sits in an output register; while the receiver stalls, the
//   next word is still accepted and worked on, and waits at its end until
//   the output register is taken.
//   Reset clears all bucket stamps and counts and empties the output.
module frame_rate_window_meter_top import fwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [STAMP_W-1:0] s_axis_tdata,  // [31:0] second
  input  logic               s_axis_tuser,  // [0] op
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [RATE_W-1:0]  m_axis_tdata,  // [15:0] rate
  output logic               m_axis_tuser   // [0] recorded
);

  fwm_cmd_t cmd;
  fwm_sts_t sts;

  fwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fwm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .op_i       (s_axis_tuser),
    .second_i   (s_axis_tdata),
    .rate_o     (m_axis_tdata),
    .recorded_o (m_axis_tuser)
  );

endmodule

FILE: tb/sv/tb_frame_rate_window_meter_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for frame_rate_window_meter_top: a directed table and random
// record/query traffic, each result checked against a bucket-table predictor or the
// fixed word of a directed row. Depends on fwm_pkg and the RTL of the block only.
module tb_frame_rate_window_meter_top;
  import fwm_pkg::*;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_QUERY  = 1'b1
  } meter_op_e;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              recorded;
  } rate_word_t;

  typedef struct packed {
    meter_op_e          op;
    logic [STAMP_W-1:0] sec;
    int                 reps;
    logic               fixed_en;
    logic [RATE_W-1:0]  fixed_rate;
    logic               fixed_rec;
  } stim_row_t;

  localparam int DIR_ROWS = 20;
  localparam int LONG_HOLD = 300;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [STAMP_W-1:0] s_axis_tdata;  // [31:0] second
  logic               s_axis_tuser;  // [0] op
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [RATE_W-1:0]  m_axis_tdata;  // [15:0] rate
  logic               m_axis_tuser;  // [0] recorded

  logic [STAMP_W-1:0] stamp_tbl [BUCKETS];
  logic [CNT_W-1:0]   count_tbl [BUCKETS];
  rate_word_t         rate_words_due [$];
  logic [STAMP_W-1:0] now_s;
  logic [1:0]         phase;
  int                 mismatch_cnt;
  int                 stall_left;
  bit                 long_hold_done;

  stim_row_t dir_tbl [DIR_ROWS] = '{
    '{OP_QUERY,  32'h0000_0000, 1, 1'b1, 16'd0, 1'b0},
    '{OP_QUERY,  32'hFFFF_FFFF, 1, 1'b1, 16'd0, 1'b0},
    '{OP_RECORD, 32'h0000_0000, 1, 1'b1, 16'd0, 1'b1},
    '{OP_RECORD, 32'hFFFF_FFFF, 2, 1'b1, 16'd0, 1'b1},
    '{OP_QUERY,  32'h5555_5555, 1, 1'b1, 16'd0, 1'b0},
    '{OP_RECORD, 32'hFFFF_FFFE, 4, 1'b1, 16'd0, 1'b1},
    '{OP_QUERY,  32'hAAAA_AAAA, 1, 1'b1, 16'd1, 1'b0},
    '{OP_RECORD, 32'h0000_0008, 1, 1'b1, 16'd0, 1'b1},
    '{OP_QUERY,  32'h0000_0000, 1, 1'b0, 16'd0, 1'b0},
    '{OP_RECORD, 32'h8000_0000, 1, 1'b1, 16'd0, 1'b1},
    '{OP_RECORD, 32'hAAAA_AAAA, 1, 1'b1, 16'd0, 1'b1},
    '{OP_QUERY,  32'h0000_0000, 1, 1'b0, 16'd0, 1'b0},
    '{OP_RECORD, 32'd1000,      2, 1'b1, 16'd0, 1'b1},
    '{OP_RECORD, 32'd1001,      2, 1'b1, 16'd0, 1'b1},
    '{OP_RECORD, 32'd1008,      1, 1'b1, 16'd0, 1'b1},
    '{OP_RECORD, 32'd1009,      1, 1'b1, 16'd0, 1'b1},
    '{OP_QUERY,  32'h0000_0000, 1, 1'b0, 16'd0, 1'b0},
    '{OP_RECORD, 32'd1010,      3, 1'b1, 16'd0, 1'b1},
    '{OP_RECORD, 32'd1011,      1, 1'b1, 16'd0, 1'b1},
    '{OP_QUERY,  32'h7FFF_FFFF, 1, 1'b0, 16'd0, 1'b0}
  };

  frame_rate_window_meter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  function automatic int src_idle_pct(input logic [1:0] ph);
    case (ph)
      2'd1:    return 29;
      2'd2:    return 50;
      default: return 0;
    endcase
  endfunction

  function automatic int snk_idle_pct(input logic [1:0] ph);
    case (ph)
      2'd1:    return 50;
      2'd2:    return 29;
      default: return 0;
    endcase
  endfunction

  function automatic rate_word_t meter_next_word(input meter_op_e op,
                                                 input logic [STAMP_W-1:0] sec);
    rate_word_t         w;
    logic [STAMP_W-1:0] limit;
    logic [STAMP_W-1:0] newest;
    logic [STAMP_W-1:0] floor_s;
    logic [31:0]        total;
    int                 victim;
    bit                 hit;
    w = '0;
    if (op == OP_RECORD) begin
      limit  = sec - STAMP_W'(BUCKETS);
      victim = 0;
      hit    = 1'b0;
      for (int i = 0; i < BUCKETS; i++) begin
        if (!hit) begin
          if (stamp_tbl[i] == sec) begin
            if (count_tbl[i] != CNT_MAX) count_tbl[i] = count_tbl[i] + 1'b1;
            hit = 1'b1;
          end else if (stamp_tbl[i] <= limit) begin
            victim = i;
          end
        end
      end
      if (!hit) begin
        stamp_tbl[victim] = sec;
        count_tbl[victim] = CNT_W'(1);
      end
      w.recorded = 1'b1;
    end else begin
      newest = '0;
      for (int i = 0; i < BUCKETS; i++)
        if (stamp_tbl[i] > newest) newest = stamp_tbl[i];
      floor_s = newest - STAMP_W'(BUCKETS);
      total   = '0;
      for (int i = 0; i < BUCKETS; i++)
        if (stamp_tbl[i] > floor_s && stamp_tbl[i] != newest) total += count_tbl[i];
      total = (total + 32'(RATE_HALF)) / 32'(RATE_DIV);
      w.rate = (total > 32'(RATE_MAX)) ? RATE_MAX : total[RATE_W-1:0];
    end
    return w;
  endfunction

  // Offer one word; returns at the edge that accepts it.
  task automatic offer_word(input meter_op_e op, input logic [STAMP_W-1:0] sec,
                            input bit fixed_en = 1'b0, input rate_word_t fixed_w = '0);
    rate_word_t w;
    while ($urandom_range(99) < src_idle_pct(phase)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sec;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    w = meter_next_word(op, sec);
    rate_words_due.push_back(fixed_en ? fixed_w : w);
  endtask

  task automatic random_run(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        offer_word(OP_RECORD, now_s);
      end else if (pick < 64) begin
        now_s = now_s + 1;
        offer_word(OP_RECORD, now_s);
      end else if (pick < 80) begin
        offer_word(OP_QUERY, $urandom);
      end else if (pick < 87) begin
        offer_word(OP_RECORD, now_s - $urandom_range(1, 12));
      end else if (pick < 92) begin
        now_s = now_s + $urandom_range(8, 11);
        offer_word(OP_RECORD, now_s);
      end else if (pick < 96) begin
        case ($urandom_range(2))
          0:       now_s = $urandom;
          1:       now_s = 32'hFFFF_FFF0 | $urandom_range(15);
          default: now_s = $urandom_range(20);
        endcase
        offer_word(OP_RECORD, now_s);
      end else begin
        offer_word(OP_RECORD, $urandom);
      end
    end
  endtask

  task automatic check_rate_word();
    rate_word_t exp_w;
    if (rate_words_due.size() == 0) begin
      $error("unexpected word: rate %0d recorded %0d", m_axis_tdata, m_axis_tuser);
      mismatch_cnt++;
    end else begin
      exp_w = rate_words_due.pop_front();
      if (exp_w.rate !== m_axis_tdata) begin
        $error("rate: expected %0d, actual %0d", exp_w.rate, m_axis_tdata);
        mismatch_cnt++;
      end
      if (exp_w.recorded !== m_axis_tuser) begin
        $error("recorded: expected %0d, actual %0d", exp_w.recorded, m_axis_tuser);
        mismatch_cnt++;
      end
    end
  endtask

  initial begin
    m_axis_tready  = 1'b0;
    stall_left     = 0;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_rate_word();
      if (phase == 2'd2 && !long_hold_done) begin
        stall_left     = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct(phase));
      end
    end
  end

  initial begin
    stim_row_t          row;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    phase         = 2'd1;
    mismatch_cnt  = 0;
    now_s         = 32'd2000;
    for (int i = 0; i < BUCKETS; i++) begin
      stamp_tbl[i] = '0;
      count_tbl[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_tbl[r];
      repeat (row.reps)
        offer_word(row.op, row.sec, row.fixed_en, '{row.fixed_rate, row.fixed_rec});
    end
    random_run(180);

    phase <= 2'd2;
    random_run(180);

    phase <= 2'd3;
    random_run(162);
    s_axis_tvalid <= 1'b0;

    while (rate_words_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_frame_rate_window_meter_top passed");
    end else begin
      $display("tb_frame_rate_window_meter_top failed");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("tb_frame_rate_window_meter_top failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/fwm_pkg.sv
src/fwm_ctrl.sv
src/fwm_dp.sv
src/frame_rate_window_meter_top.sv
tb/sv/tb_frame_rate_window_meter_top.sv
